@@ hdl/hdp_pkg.sv @@
package hdp_pkg;

   // Nesting limits
   localparam int GLOBAL_STACK_DEPTH = 8;
   localparam int COLLECTION_DEPTH   = 16;

   localparam int STACK_IDX_W = (GLOBAL_STACK_DEPTH > 1) ? $clog2(GLOBAL_STACK_DEPTH) : 1;
   localparam int STACK_CNT_W = $clog2(GLOBAL_STACK_DEPTH + 1);
   localparam int DEPTH_W     = $clog2(COLLECTION_DEPTH + 1);

   // One seen entry per report ID value
   localparam int ID_MAP_DEPTH = 256;

   typedef enum logic [2:0] {
      ERR_NONE         = 3'd0,
      ERR_RESERVED     = 3'd1,
      ERR_POP_UNDER    = 3'd2,
      ERR_ENDCOL_UNDER = 3'd3,
      ERR_NO_ID        = 3'd4,
      ERR_PUSH_OVER    = 3'd5,
      ERR_COL_OVER     = 3'd6,
      ERR_TRUNC        = 3'd7
   } error_type;

   typedef enum logic [1:0] {
      CLASS_MAIN     = 2'd0,
      CLASS_GLOBAL   = 2'd1,
      CLASS_LOCAL    = 2'd2,
      CLASS_RESERVED = 2'd3
   } item_class_type;

   // Main item tags
   localparam logic [3:0] TAG_INPUT          = 4'h8;
   localparam logic [3:0] TAG_OUTPUT         = 4'h9;
   localparam logic [3:0] TAG_COLLECTION     = 4'hA;
   localparam logic [3:0] TAG_FEATURE        = 4'hB;
   localparam logic [3:0] TAG_END_COLLECTION = 4'hC;

   // Global item tags
   localparam logic [3:0] TAG_REPORT_ID = 4'h8;
   localparam logic [3:0] TAG_PUSH      = 4'hA;
   localparam logic [3:0] TAG_POP       = 4'hB;

   // Report kinds
   localparam logic [1:0] KIND_INPUT   = 2'd0;
   localparam logic [1:0] KIND_OUTPUT  = 2'd1;
   localparam logic [1:0] KIND_FEATURE = 2'd2;

   // Tracked report ID: valid flag plus the ID byte
   typedef struct packed {
      logic       valid;
      logic [7:0] id;
   } report_id_type;

   // Result of one parsed byte, handed to the report tracker
   typedef struct packed {
      logic       has_report;
      logic [7:0] report_id;
      logic [1:0] report_kind;
      error_type  error_code;
      logic       descriptor_done;
   } hdp_event_type;

   // Data byte count of a short item size code
   function automatic logic [2:0] size_of_code(input logic [1:0] code);
      logic [2:0] size;
      case (code)
         2'd0:    size = 3'd0;
         2'd1:    size = 3'd1;
         2'd2:    size = 3'd2;
         default: size = 3'd4;
      endcase
      return size;
   endfunction

endpackage

@@ hdl/hdp_req_if.sv @@
interface hdp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       is_final;

   modport source(output valid, output data_byte, output is_final, input ready);
   modport sink(input valid, input data_byte, input is_final, output ready);
endinterface

@@ hdl/hdp_rsp_if.sv @@
interface hdp_rsp_if;
   logic       valid;
   logic       ready;
   logic       has_report;
   logic [7:0] report_id;
   logic [1:0] report_kind;
   logic       newly_seen;
   logic [2:0] error_code;
   logic       descriptor_done;

   modport source(output valid, output has_report, output report_id, output report_kind,
                  output newly_seen, output error_code, output descriptor_done,
                  input ready);
   modport sink(input valid, input has_report, input report_id, input report_kind,
                input newly_seen, input error_code, input descriptor_done,
                output ready);
endinterface

@@ hdl/hdp_item_parser.sv @@
module hdp_item_parser (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  byte_fire,
   input  logic [7:0]            data_byte,
   input  logic                  is_final,
   output logic                  ev_valid,
   output hdp_pkg::hdp_event_type ev
);
   import hdp_pkg::*;

   logic [7:0]             prefix_ff, prefix_in;
   logic [2:0]             bytes_left_ff, bytes_left_in;
   logic [7:0]             id_byte_ff, id_byte_in;
   report_id_type          cur_id_ff, cur_id_in;
   report_id_type          stack_ff [GLOBAL_STACK_DEPTH];
   logic [STACK_CNT_W-1:0] stack_cnt_ff, stack_cnt_in;
   logic [DEPTH_W-1:0]     depth_ff, depth_in;

   logic                   awaiting;
   logic [7:0]             prefix_now;
   logic [2:0]             size_new;
   logic                   first_data;
   logic                   complete;
   logic [7:0]             id_value;
   item_class_type         item_class;
   logic [3:0]             tag;
   error_type              err;
   logic                   has;
   logic [1:0]             kind;
   logic                   push_en;
   logic [STACK_IDX_W-1:0] push_idx;
   logic [STACK_IDX_W-1:0] pop_idx;
   logic [STACK_CNT_W-1:0] cnt_dec;

   // Assemble the item: prefix first, then its data bytes
   always_comb begin
      awaiting   = (bytes_left_ff == 3'd0);
      prefix_now = awaiting ? data_byte : prefix_ff;
      size_new   = size_of_code(data_byte[1:0]);
      first_data = !awaiting && (bytes_left_ff == size_of_code(prefix_ff[1:0]));
      complete   = awaiting ? (size_new == 3'd0) : (bytes_left_ff == 3'd1);
      id_value   = awaiting ? 8'd0 : (first_data ? data_byte : id_byte_ff);
      prefix_in  = prefix_now;
      id_byte_in = first_data ? data_byte : id_byte_ff;
      if (awaiting) begin
         bytes_left_in = size_new;
      end else begin
         bytes_left_in = bytes_left_ff - 3'd1;
      end
      // drop a partial item on the final byte
      if (!complete && is_final) begin
         bytes_left_in = 3'd0;
      end
   end

   // Act on a completed item
   always_comb begin
      item_class   = item_class_type'(prefix_now[3:2]);
      tag          = prefix_now[7:4];
      err          = ERR_NONE;
      has          = 1'b0;
      kind         = KIND_INPUT;
      cur_id_in    = cur_id_ff;
      stack_cnt_in = stack_cnt_ff;
      depth_in     = depth_ff;
      push_en      = 1'b0;
      push_idx     = stack_cnt_ff[STACK_IDX_W-1:0];
      cnt_dec      = stack_cnt_ff - 1'b1;
      pop_idx      = cnt_dec[STACK_IDX_W-1:0];
      if (complete) begin
         case (item_class)
            CLASS_RESERVED: begin
               err = ERR_RESERVED;
            end
            CLASS_MAIN: begin
               if (tag == TAG_INPUT || tag == TAG_OUTPUT || tag == TAG_FEATURE) begin
                  if (!cur_id_ff.valid) begin
                     err = ERR_NO_ID;
                  end else begin
                     has  = 1'b1;
                     kind = (tag == TAG_INPUT)  ? KIND_INPUT :
                            (tag == TAG_OUTPUT) ? KIND_OUTPUT : KIND_FEATURE;
                  end
               end else if (tag == TAG_COLLECTION) begin
                  if (depth_ff >= DEPTH_W'(COLLECTION_DEPTH)) begin
                     err = ERR_COL_OVER;
                  end else begin
                     depth_in = depth_ff + 1'b1;
                  end
               end else if (tag == TAG_END_COLLECTION) begin
                  if (depth_ff == '0) begin
                     err = ERR_ENDCOL_UNDER;
                  end else begin
                     depth_in = depth_ff - 1'b1;
                  end
               end
            end
            CLASS_GLOBAL: begin
               if (tag == TAG_PUSH) begin
                  if (stack_cnt_ff >= STACK_CNT_W'(GLOBAL_STACK_DEPTH)) begin
                     err = ERR_PUSH_OVER;
                  end else begin
                     push_en      = 1'b1;
                     stack_cnt_in = stack_cnt_ff + 1'b1;
                  end
               end else if (tag == TAG_POP) begin
                  if (stack_cnt_ff == '0) begin
                     err = ERR_POP_UNDER;
                  end else begin
                     stack_cnt_in = cnt_dec;
                     cur_id_in    = stack_ff[pop_idx];
                  end
               end else if (tag == TAG_REPORT_ID) begin
                  cur_id_in = '{valid: 1'b1, id: id_value};
               end
            end
            default: begin
               // local items carry nothing tracked here
            end
         endcase
      end else if (is_final) begin
         err = ERR_TRUNC;
      end
   end

   // Emit a result on a report, an error or the final byte
   always_comb begin
      ev_valid           = is_final || has || (err != ERR_NONE);
      ev.has_report      = has;
      ev.report_id       = has ? cur_id_ff.id : 8'd0;
      ev.report_kind     = kind;
      ev.error_code      = err;
      ev.descriptor_done = is_final;
   end

   // Hold parser state; advance on each byte transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         prefix_ff     <= '0;
         bytes_left_ff <= '0;
         id_byte_ff    <= '0;
         cur_id_ff     <= '0;
         stack_cnt_ff  <= STACK_CNT_W'(1);
         depth_ff      <= '0;
      end else if (byte_fire) begin
         prefix_ff     <= prefix_in;
         bytes_left_ff <= bytes_left_in;
         id_byte_ff    <= id_byte_in;
         cur_id_ff     <= cur_id_in;
         stack_cnt_ff  <= stack_cnt_in;
         depth_ff      <= depth_in;
      end
   end

   // Global stack: bottom entry starts cleared
   always_ff @(posedge clock) begin
      if (reset) begin
         stack_ff[0] <= '0;
      end else if (byte_fire && push_en) begin
         stack_ff[push_idx] <= cur_id_ff;
      end
   end

endmodule

@@ hdl/hdp_report_tracker.sv @@
module hdp_report_tracker (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   ev_load,
   input  hdp_pkg::hdp_event_type ev,
   output logic                   can_load,
   hdp_rsp_if.source              rsp_bus
);
   import hdp_pkg::*;

   logic          stage_valid_ff, stage_valid_in;
   hdp_event_type stage_ev_ff;
   logic [2:0]    seen_rd_ff;
   logic          fwd_hit_ff;
   logic [2:0]    fwd_val_ff;

   logic [2:0]    seen_mem [ID_MAP_DEPTH];
   logic          seen_vld_ff [ID_MAP_DEPTH];

   logic          out_valid_ff, out_valid_in;
   logic          out_has_ff;
   logic [7:0]    out_id_ff;
   logic [1:0]    out_kind_ff;
   logic          out_fresh_ff;
   logic [2:0]    out_err_ff;
   logic          out_done_ff;

   logic          stage_fire;
   logic [2:0]    seen_cur;
   logic [2:0]    seen_merged;
   logic          fresh;
   logic          hazard;

   // Advance the stage when the output register is free or being drained
   always_comb begin
      stage_fire     = stage_valid_ff && (!out_valid_ff || rsp_bus.ready);
      can_load       = !stage_valid_ff || stage_fire;
      stage_valid_in = ev_load || (stage_valid_ff && !stage_fire);
      out_valid_in   = stage_fire || (out_valid_ff && !rsp_bus.ready);
   end

   // Merge the seen bits, forwarding the write of the previous report
   always_comb begin
      seen_cur    = fwd_hit_ff ? fwd_val_ff : seen_rd_ff;
      fresh       = stage_ev_ff.has_report && !seen_cur[stage_ev_ff.report_kind];
      seen_merged = seen_cur | (3'b001 << stage_ev_ff.report_kind);
      hazard      = stage_fire && stage_ev_ff.has_report &&
                    (stage_ev_ff.report_id == ev.report_id);
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   // Seen valid bits: cleared at once by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ID_MAP_DEPTH; i++) begin
            seen_vld_ff[i] <= 1'b0;
         end
      end else if (stage_fire && stage_ev_ff.has_report) begin
         seen_vld_ff[stage_ev_ff.report_id] <= 1'b1;
      end
   end

   // Seen map memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (stage_fire && stage_ev_ff.has_report) begin
         seen_mem[stage_ev_ff.report_id] <= seen_merged;
      end
   end

   // Load the stage and issue the seen read
   always_ff @(posedge clock) begin
      if (ev_load) begin
         stage_ev_ff <= ev;
         seen_rd_ff  <= seen_vld_ff[ev.report_id] ? seen_mem[ev.report_id] : 3'b000;
         fwd_hit_ff  <= hazard;
         fwd_val_ff  <= seen_merged;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (stage_fire) begin
         out_has_ff   <= stage_ev_ff.has_report;
         out_id_ff    <= stage_ev_ff.report_id;
         out_kind_ff  <= stage_ev_ff.report_kind;
         out_fresh_ff <= fresh;
         out_err_ff   <= stage_ev_ff.error_code;
         out_done_ff  <= stage_ev_ff.descriptor_done;
      end
   end

   assign rsp_bus.valid           = out_valid_ff;
   assign rsp_bus.has_report      = out_has_ff;
   assign rsp_bus.report_id       = out_id_ff;
   assign rsp_bus.report_kind     = out_kind_ff;
   assign rsp_bus.newly_seen      = out_fresh_ff;
   assign rsp_bus.error_code      = out_err_ff;
   assign rsp_bus.descriptor_done = out_done_ff;

endmodule

@@ hdl/hid_report_descriptor_parser.sv @@
// HID report descriptor parser. Takes one descriptor byte per transfer and
// can take a byte in every cycle; a result is registered in the stage
// register (parsed event and seen-map read), then merged into the output
// register. While a finished result waits in the output register, bytes
// keep flowing until a second result is held in the stage register; then
// the input stalls until the output is taken. A result
// comes out only for a byte that completes an Input, Output or Feature item,
// completes a faulty item, or is marked final. Report ID, the Push/Pop
// stack, collection depth and the seen map persist across descriptors; only
// the item being assembled is dropped at a final byte. The seen map is
// cleared by reset at once, with no clearing pass.
module hid_report_descriptor_parser (
   input logic       clock,
   input logic       reset,
   hdp_req_if.sink   req_bus,
   hdp_rsp_if.source rsp_bus
);
   import hdp_pkg::*;

   logic          byte_fire;
   logic          can_load;
   logic          ev_valid;
   hdp_event_type ev;

   assign req_bus.ready = can_load;
   assign byte_fire     = req_bus.valid && can_load;

   hdp_item_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .byte_fire (byte_fire),
      .data_byte (req_bus.data_byte),
      .is_final  (req_bus.is_final),
      .ev_valid  (ev_valid),
      .ev        (ev)
   );

   hdp_report_tracker u_tracker (
      .clock    (clock),
      .reset    (reset),
      .ev_load  (byte_fire && ev_valid),
      .ev       (ev),
      .can_load (can_load),
      .rsp_bus  (rsp_bus)
   );

endmodule

@@ hdl/hdp_checker.sv @@
module hdp_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       has_report,
   input logic [7:0] report_id,
   input logic [1:0] report_kind,
   input logic       newly_seen,
   input logic [2:0] error_code,
   input logic       descriptor_done
);
   import hdp_pkg::*;

   // A declared report never carries an error
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && has_report |-> error_code == ERR_NONE)
      else $error("report with error code");

   // Without a report the report fields stay zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !has_report |-> report_id == 8'd0 && !newly_seen)
      else $error("report fields set without report");

   // Truncation is only flagged on the final byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && error_code == ERR_TRUNC |-> descriptor_done)
      else $error("truncation without final byte");

   // Kind code three is never produced
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> report_kind != 2'd3)
      else $error("bad report kind");

   // Stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(report_id) && $stable(error_code))
      else $error("stalled result changed");

endmodule

bind hid_report_descriptor_parser hdp_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .has_report      (rsp_bus.has_report),
   .report_id       (rsp_bus.report_id),
   .report_kind     (rsp_bus.report_kind),
   .newly_seen      (rsp_bus.newly_seen),
   .error_code      (rsp_bus.error_code),
   .descriptor_done (rsp_bus.descriptor_done)
);
